// ===== rtl/rwbc_pkg.sv =====
package rwbc_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 3;
  localparam int unsigned MaxBytes  = 7;
  localparam int unsigned DataW     = MaxBytes * ByteW;

  // longest burst, 1..7
  localparam logic [LenW-1:0] MaxBurst = LenW'(7);

  // result queue depth, at least 2
  localparam int unsigned FifoDepth = 4;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] bytes;
    logic [LenW-1:0]  len;
    logic             last;
  } burst_t;

  // up to two bursts pushed per accepted beat
  typedef struct packed {
    logic [1:0] cnt;
    burst_t     first;
    burst_t     second;
  } push_t;

endpackage

// ===== rtl/rwbc_fifo.sv =====
module rwbc_fifo #(
  parameter int unsigned Depth = rwbc_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwbc_pkg::push_t     push_i,
  output logic                room2_o,
  output logic                valid_o,
  input  logic                ready_i,
  output rwbc_pkg::burst_t    data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rwbc_pkg::burst_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_1, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop      = valid_o && ready_i;
  assign wr_ptr_1 = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.cnt == 2'd1) begin
      wr_ptr_d = wr_ptr_1;
    end else if (push_i.cnt == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr_1);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_1] <= push_i.second;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room2_o = (count_q <= CntW'(Depth - 2));

endmodule

// ===== rtl/register_write_burst_coalescer_top.sv =====
// Merges single-byte register writes with consecutive addresses into bursts of up to seven
// bytes (start address, bytes packed first byte lowest, length). One write is accepted per
// cycle; each beat is compared against the open run and appended or closes it in the same
// cycle, and the finished bursts go into a small result queue (FIFO_DEPTH entries) that
// drains one burst per cycle while out_ready_i is high. A write marked final flushes the
// run, so it may push two bursts; the input stalls only while the queue has fewer than
// two free entries. Closed bursts are registered and leave the queue in order.
module register_write_burst_coalescer_top #(
  parameter int unsigned FIFO_DEPTH = rwbc_pkg::FifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rwbc_pkg::AddrW-1:0]    write_addr_i,
  input  logic [rwbc_pkg::ByteW-1:0]    write_byte_i,
  input  logic                          final_write_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rwbc_pkg::AddrW-1:0]    burst_addr_o,
  output logic [rwbc_pkg::DataW-1:0]    burst_bytes_o,
  output logic [rwbc_pkg::LenW-1:0]     burst_len_o,
  output logic                          final_burst_o
);

  logic [rwbc_pkg::AddrW-1:0] run_start_q, run_start_d;
  logic [rwbc_pkg::LenW-1:0]  run_len_q, run_len_d;
  logic [rwbc_pkg::DataW-1:0] run_data_q, run_data_d;
  logic                       run_open_q, run_open_d;

  logic                       accept, contig, closing;
  logic [rwbc_pkg::AddrW:0]   next_addr;
  rwbc_pkg::burst_t           closed_burst, final_b, out_b;
  rwbc_pkg::push_t            push;

  assign accept    = in_valid_i && in_ready_o;
  // no wrap: a run ending at the top address is never continued at zero
  assign next_addr = {1'b0, run_start_q} + (rwbc_pkg::AddrW + 1)'(run_len_q);
  assign contig    = ({1'b0, write_addr_i} == next_addr) && (run_len_q < rwbc_pkg::MaxBurst);
  assign closing   = run_open_q && !contig;

  always_comb begin
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    run_data_d  = run_data_q;
    run_open_d  = run_open_q;
    if (!run_open_q || !contig) begin
      run_start_d = write_addr_i;
      run_len_d   = rwbc_pkg::LenW'(1);
      run_data_d  = rwbc_pkg::DataW'(write_byte_i);
      run_open_d  = 1'b1;
    end else begin
      run_data_d = run_data_q
                 | (rwbc_pkg::DataW'(write_byte_i) << {run_len_q, 3'b000});
      run_len_d  = run_len_q + rwbc_pkg::LenW'(1);
    end

    closed_burst = '{addr: run_start_q, bytes: run_data_q, len: run_len_q, last: 1'b0};
    final_b      = '{addr: run_start_d, bytes: run_data_d, len: run_len_d, last: 1'b1};

    if (final_write_i) begin
      run_open_d = 1'b0;
      run_len_d  = '0;
    end

    push.first  = closing ? closed_burst : final_b;
    push.second = final_b;
    push.cnt    = 2'd0;
    if (accept) begin
      push.cnt = 2'({1'b0, closing} + {1'b0, final_write_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_start_q <= '0;
      run_len_q   <= '0;
      run_open_q  <= 1'b0;
    end else if (accept) begin
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      run_open_q  <= run_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_data_q <= run_data_d;
    end
  end

  rwbc_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_b)
  );

  assign burst_addr_o  = out_b.addr;
  assign burst_bytes_o = out_b.bytes;
  assign burst_len_o   = out_b.len;
  assign final_burst_o = out_b.last;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (burst_len_o != '0) && (burst_len_o <= rwbc_pkg::MaxBurst))
    else $error("burst length out of range");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_open_q == (run_len_q != '0)))
    else $error("run length disagrees with open flag");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_write_i) |=> !run_open_q && out_valid_o)
    else $error("final write did not flush the run");

endmodule
